### design/lbes_pkg.sv
// Shared types and constants of the laser beam endpoint scorer.
package lbes_pkg;

  // Fixed-point and scan constants.
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned BEAMS      = 720;
  localparam int unsigned ANGLE_BITS = 16;

  // Angle bits below the trig resolution are cleared before the lookup.
  localparam logic [15:0] ANGLE_MASK =
    (ANGLE_BITS < 16) ? 16'(16'hFFFF << (16 - ANGLE_BITS)) : 16'hFFFF;

  // Field widths.
  localparam int unsigned CFG_W = 18;
  localparam int unsigned LEN_W = 19;
  localparam int unsigned SIN_W = 16;
  localparam int unsigned POS_W = 19;

  // Sine polynomial coefficients, Q14.
  localparam logic [14:0] TRIG_A = 15'd10512;
  localparam logic [10:0] TRIG_B = 11'd1160;
  localparam logic [14:0] TRIG_C = 15'd25736;
  localparam logic [14:0] QUARTER = 15'd16384;

  // Item kinds.
  typedef enum logic [1:0] {
    ACT_MAP  = 2'd0,
    ACT_POSE = 2'd1,
    ACT_BEAM = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RANGE_MIN  = 3'd0,
    CFG_RANGE_MAX  = 3'd1,
    CFG_ANGLE_STEP = 3'd2,
    CFG_SENSOR_OFF = 3'd3,
    CFG_X_MIN      = 3'd4,
    CFG_X_MAX      = 3'd5,
    CFG_Y_MIN      = 3'd6,
    CFG_Y_MAX      = 3'd7
  } cfg_idx_e;

endpackage

### design/laser_beam_endpoint_scorer_core.sv
// Top level of the laser beam endpoint scorer: pipeline, occupancy map and scoring.
//
// Usage. Items enter on the in channel (in_valid_i / in_stall_o) and results leave
// on the out channel (out_valid_o / out_stall_i); a beat moves when valid is high
// and stall is low. A map item writes one occupancy bit, a pose item places the
// sensor and starts a scan, a beam item scores one range. Only the final beam of
// a scan produces a result beat carrying weight_o and pose_blocked_o.
// Throughput is one item per cycle for every item kind, except while the map is
// cleared or a result waits on a stalled receiver. From the input beat to the result
// beat, the beam angle is formed into the input register at the input beat, then
// come the sine polynomial pipeline, the length multiply, the rounding, the position
// add and the map read, and the output register.
// All map traffic happens at one pipeline stage in item order on a map memory with
// one write port and two read ports, so no forwarding is needed there.
// After reset the map is cleared one cell per cycle, all 2^(MAP_ROW_BITS+MAP_COL_BITS)
// cells (262144 by default); in_stall_o stays high during that pass, while
// configuration writes are taken at any time.
// When the receiver stalls, a finished result waits in the output register and
// the pipeline keeps taking items until the next result reaches the last stage.
module laser_beam_endpoint_scorer_core #(
  parameter int unsigned MAP_ROW_BITS = 9,
  parameter int unsigned MAP_COL_BITS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [8:0]  cell_row_i,
  input  logic [8:0]  cell_col_i,
  input  logic        cell_occupied_i,
  input  logic [16:0] pose_x_i,
  input  logic [16:0] pose_y_i,
  input  logic [15:0] pose_heading_i,
  input  logic [17:0] beam_range_i,
  input  logic        last_beam_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  weight_o,
  output logic        pose_blocked_o
);

  localparam int unsigned AW    = MAP_ROW_BITS + MAP_COL_BITS;
  localparam int unsigned CELLS = 1 << AW;
  localparam int unsigned PW    = 26;
  localparam int unsigned FB    = lbes_pkg::FRAC_BITS;

  // Item fields carried alongside the trig pipeline.
  typedef struct packed {
    lbes_pkg::action_e               act;
    logic signed [lbes_pkg::LEN_W-1:0] len;
    logic                            rok;
    logic                            endf;
    logic [16:0]                     px;
    logic [16:0]                     py;
    logic [8:0]                      row;
    logic [8:0]                      col;
    logic                            occ;
  } item_t;

  // Configuration registers.
  logic [17:0] cfg_rmin_q, cfg_rmax_q;
  logic [15:0] cfg_step_q;
  logic signed [15:0] cfg_off_q;
  logic [8:0]  cfg_xmin_q, cfg_xmax_q, cfg_ymin_q, cfg_ymax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rmin_q <= 18'd0;
      cfg_rmax_q <= 18'd262143;
      cfg_step_q <= 16'd91;
      cfg_off_q  <= 16'sd0;
      cfg_xmin_q <= 9'd0;
      cfg_xmax_q <= 9'd511;
      cfg_ymin_q <= 9'd0;
      cfg_ymax_q <= 9'd511;
    end else if (cfg_we_i) begin
      unique case (lbes_pkg::cfg_idx_e'(cfg_idx_i))
        lbes_pkg::CFG_RANGE_MIN:  cfg_rmin_q <= cfg_data_i;
        lbes_pkg::CFG_RANGE_MAX:  cfg_rmax_q <= cfg_data_i;
        lbes_pkg::CFG_ANGLE_STEP: cfg_step_q <= cfg_data_i[15:0];
        lbes_pkg::CFG_SENSOR_OFF: cfg_off_q  <= $signed(cfg_data_i[15:0]);
        lbes_pkg::CFG_X_MIN:      cfg_xmin_q <= cfg_data_i[8:0];
        lbes_pkg::CFG_X_MAX:      cfg_xmax_q <= cfg_data_i[8:0];
        lbes_pkg::CFG_Y_MIN:      cfg_ymin_q <= cfg_data_i[8:0];
        lbes_pkg::CFG_Y_MAX:      cfg_ymax_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic [8:1] vld_q;
  logic       en;
  logic       in_fire;
  logic       clearing_q;
  logic [AW:0] clr_q;
  logic       res_pend;

  lbes_pkg::action_e act_in;
  assign act_in     = lbes_pkg::action_e'(action_i);
  assign in_stall_o = clearing_q || !en;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Front state: heading and beam index, known at the input beat.
  logic [15:0] head_q;
  logic [9:0]  beam_cnt_q;
  logic [25:0] step_prod;
  logic        scan_end;
  logic [15:0] ang_in;

  assign step_prod = beam_cnt_q * cfg_step_q;
  assign scan_end  = last_beam_i ||
                     (({1'b0, beam_cnt_q} + 11'd1) >= 11'(lbes_pkg::BEAMS));

  always_comb begin
    if (act_in == lbes_pkg::ACT_BEAM) begin
      ang_in = head_q + 16'h8000 + step_prod[15:0];
    end else begin
      ang_in = pose_heading_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= 16'd0;
      beam_cnt_q <= 10'd0;
    end else if (in_fire) begin
      if (act_in == lbes_pkg::ACT_POSE) begin
        head_q     <= pose_heading_i;
        beam_cnt_q <= 10'd0;
      end else if (act_in == lbes_pkg::ACT_BEAM) begin
        beam_cnt_q <= scan_end ? 10'd0 : beam_cnt_q + 10'd1;
      end
    end
  end

  // Stage one registers and the sideband shift line.
  item_t       item_in;
  item_t       sb_q [1:7];
  logic [15:0] ang1_q;

  always_comb begin
    item_in.act  = act_in;
    item_in.len  = (act_in == lbes_pkg::ACT_BEAM) ? $signed({1'b0, beam_range_i})
                                                  : lbes_pkg::LEN_W'(cfg_off_q);
    item_in.rok  = (beam_range_i >= cfg_rmin_q) && (beam_range_i <= cfg_rmax_q);
    item_in.endf = scan_end;
    item_in.px   = pose_x_i;
    item_in.py   = pose_y_i;
    item_in.row  = cell_row_i;
    item_in.col  = cell_col_i;
    item_in.occ  = cell_occupied_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang1_q  <= ang_in;
      sb_q[1] <= item_in;
      for (int k = 2; k <= 7; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:1], in_fire && (act_in != lbes_pkg::ACT_NONE)};
    end
  end

  // Cosine and sine lanes.
  logic signed [lbes_pkg::SIN_W-1:0] cos_v, sin_v;

  lbes_trig_lane u_cos (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang1_q + 16'h4000),
    .sin_o   (cos_v)
  );

  lbes_trig_lane u_sin (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang1_q),
    .sin_o   (sin_v)
  );

  // Length times trig, then round back to the fixed-point position scale.
  logic signed [34:0] prod_x_q, prod_y_q;
  logic signed [35:0] rnd_x, rnd_y;
  logic signed [21:0] sc_x_q, sc_y_q;

  assign rnd_x = 36'(prod_x_q) + 36'sd8192;
  assign rnd_y = 36'(prod_y_q) + 36'sd8192;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= sb_q[5].len * cos_v;
      prod_y_q <= sb_q[5].len * sin_v;
      sc_x_q   <= rnd_x[35:14];
      sc_y_q   <= rnd_y[35:14];
    end
  end

  // Position stage: endpoint or sensor position, bounds and map addresses.
  logic signed [lbes_pkg::POS_W-1:0] sensor_x_q, sensor_y_q;
  logic signed [PW-1:0] base_x, base_y, pos_x, pos_y;
  logic signed [PW-1:0] xlo, xhi, ylo, yhi;
  logic [PW-1:0]        pcx, pcy;
  logic                 pos_on, pose_on, in_box;
  logic [11:0]          wrow, wcol;
  logic                 wr_ok;
  logic [AW-1:0]        raddr_a, raddr_b, waddr;
  logic                 mem_we, wdata;
  item_t                it7;

  assign it7 = sb_q[7];

  always_comb begin
    if (it7.act == lbes_pkg::ACT_POSE) begin
      base_x = $signed(PW'(it7.px));
      base_y = $signed(PW'(it7.py));
    end else begin
      base_x = PW'(sensor_x_q);
      base_y = PW'(sensor_y_q);
    end
    pos_x = base_x + PW'(sc_x_q);
    pos_y = base_y + PW'(sc_y_q);
    pcx   = PW'(it7.px);
    pcy   = PW'(it7.py);
    xlo   = $signed(PW'(cfg_xmin_q) << FB);
    xhi   = $signed(PW'(cfg_xmax_q) << FB);
    ylo   = $signed(PW'(cfg_ymin_q) << FB);
    yhi   = $signed(PW'(cfg_ymax_q) << FB);
    // Negative values have the top bit set and so fall off the grid too.
    pos_on  = ((PW'(pos_x) >> (FB + MAP_COL_BITS)) == '0) &&
              ((PW'(pos_y) >> (FB + MAP_ROW_BITS)) == '0);
    pose_on = ((pcx >> (FB + MAP_COL_BITS)) == '0) &&
              ((pcy >> (FB + MAP_ROW_BITS)) == '0);
    in_box  = (pos_x >= xlo) && (pos_x <= xhi) && (pos_y >= ylo) && (pos_y <= yhi);
    raddr_a = {pos_y[FB +: MAP_ROW_BITS], pos_x[FB +: MAP_COL_BITS]};
    raddr_b = {pcy[FB +: MAP_ROW_BITS], pcx[FB +: MAP_COL_BITS]};
    wrow    = 12'(it7.row);
    wcol    = 12'(it7.col);
    wr_ok   = ((wrow >> MAP_ROW_BITS) == '0) && ((wcol >> MAP_COL_BITS) == '0);
    if (clearing_q) begin
      mem_we = 1'b1;
      waddr  = clr_q[AW-1:0];
      wdata  = 1'b0;
    end else begin
      mem_we = en && vld_q[7] && (it7.act == lbes_pkg::ACT_MAP) && wr_ok;
      waddr  = {wrow[MAP_ROW_BITS-1:0], wcol[MAP_COL_BITS-1:0]};
      wdata  = it7.occ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_x_q <= '0;
      sensor_y_q <= '0;
    end else if (en && vld_q[7] && (it7.act == lbes_pkg::ACT_POSE)) begin
      sensor_x_q <= pos_x[lbes_pkg::POS_W-1:0];
      sensor_y_q <= pos_y[lbes_pkg::POS_W-1:0];
    end
  end

  // Clearing pass over the map after reset.
  assign clearing_q = !clr_q[AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Occupancy map: one write port, two registered read ports.
  logic map_mem [0:CELLS-1];
  logic rda_q, rdb_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[waddr] <= wdata;
    end
    if (en) begin
      rda_q <= map_mem[raddr_a];
      rdb_q <= map_mem[raddr_b];
    end
  end

  // Last stage registers.
  lbes_pkg::action_e act8_q;
  logic rok8_q, end8_q, bin8_q, pon8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      act8_q <= it7.act;
      rok8_q <= it7.rok;
      end8_q <= it7.endf;
      bin8_q <= in_box && pos_on;
      pon8_q <= pose_on && pos_on;
    end
  end

  // Scoring: blocked flag, hit count and the result beat.
  logic       blocked_q;
  logic [9:0] hit_q, hit_new;
  logic       hit_inc;
  logic       out_valid_q, out_blk_q;
  logic [9:0] weight_q;

  assign res_pend = vld_q[8] && (act8_q == lbes_pkg::ACT_BEAM) && end8_q;
  assign en       = !(res_pend && out_valid_q && out_stall_i);
  assign hit_inc  = !blocked_q && rok8_q && bin8_q && !rda_q && (hit_q != 10'h3FF);
  assign hit_new  = hit_q + 10'(hit_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= 1'b0;
      hit_q     <= 10'd0;
    end else if (en && vld_q[8]) begin
      if (act8_q == lbes_pkg::ACT_POSE) begin
        blocked_q <= !pon8_q || rda_q || rdb_q;
        hit_q     <= 10'd0;
      end else if (act8_q == lbes_pkg::ACT_BEAM) begin
        hit_q <= end8_q ? 10'd0 : hit_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && res_pend) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res_pend) begin
      weight_q  <= blocked_q ? 10'd0 : hit_new;
      out_blk_q <= blocked_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weight_o       = weight_q;
  assign pose_blocked_o = out_blk_q;

  // No item enters while the map is being cleared.
  ap_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_fire)
    else $error("item accepted during map clearing");

  // The pipeline is empty during the clearing pass.
  ap_empty_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (vld_q == '0))
    else $error("pipeline busy during map clearing");

  // The pipeline only halts on a result that cannot be delivered.
  ap_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> (res_pend && out_valid_q))
    else $error("pipeline halted without a waiting result");

  // A blocked pose always scores zero.
  ap_blocked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pose_blocked_o) |-> (weight_o == 10'd0))
    else $error("blocked pose gave a nonzero weight");

endmodule

### design/lbes_trig_lane.sv
// Four-stage pipelined Q14 sine lane built from a quadrant-folded polynomial.
module lbes_trig_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [15:0]                         angle_i,
  output logic signed [lbes_pkg::SIN_W-1:0]   sin_o
);

  logic [15:0] ang_m;
  logic [14:0] x0;
  logic [29:0] sq;
  logic [14:0] x2_q, x3_q, x4_q;
  logic        neg2_q, neg3_q, neg4_q;
  logic [14:0] s2_q, s3_q;
  logic [25:0] p1;
  logic [13:0] t1_q;
  logic [28:0] p2;
  logic [14:0] t2_q;
  logic [29:0] p3;
  logic [15:0] y_mag;
  logic signed [lbes_pkg::SIN_W-1:0] sin_q;

  // Fold the angle into the first quadrant and square it.
  always_comb begin
    ang_m = angle_i & lbes_pkg::ANGLE_MASK;
    if (ang_m[14]) begin
      x0 = lbes_pkg::QUARTER - {1'b0, ang_m[13:0]};
    end else begin
      x0 = {1'b0, ang_m[13:0]};
    end
    sq = x0 * x0;
  end

  // Polynomial terms, one multiply per stage.
  assign p1    = lbes_pkg::TRIG_B * s2_q;
  assign p2    = t1_q * s3_q;
  assign p3    = t2_q * x4_q;
  assign y_mag = p3[29:14];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q   <= x0;
      neg2_q <= ang_m[15];
      s2_q   <= sq[28:14];
      x3_q   <= x2_q;
      neg3_q <= neg2_q;
      s3_q   <= s2_q;
      t1_q   <= 14'(lbes_pkg::TRIG_A - 15'(p1[25:14]));
      x4_q   <= x3_q;
      neg4_q <= neg3_q;
      t2_q   <= lbes_pkg::TRIG_C - p2[28:14];
      sin_q  <= neg4_q ? -$signed(y_mag) : $signed(y_mag);
    end
  end

  assign sin_o = sin_q;

endmodule

### verif/tb.sv
// Testbench of the laser beam endpoint scorer: predicts each weight and compares it.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned GRID_CELLS = 1 << 18;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [17:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [8:0]  cell_row_i;
  logic [8:0]  cell_col_i;
  logic        cell_occupied_i;
  logic [16:0] pose_x_i;
  logic [16:0] pose_y_i;
  logic [15:0] pose_heading_i;
  logic [17:0] beam_range_i;
  logic        last_beam_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [9:0]  weight_o;
  logic        pose_blocked_o;

  laser_beam_endpoint_scorer_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .action_i, .cell_row_i, .cell_col_i,
    .cell_occupied_i, .pose_x_i, .pose_y_i, .pose_heading_i,
    .beam_range_i, .last_beam_i, .out_valid_o, .out_stall_i,
    .weight_o, .pose_blocked_o
  );

  typedef struct packed {
    logic [9:0] weight;
    logic       blocked;
  } score_t;

  // Mirror of the block state.
  bit          grid_occ [GRID_CELLS];
  logic [17:0] win_lo, win_hi;
  logic [15:0] beam_step;
  logic signed [15:0] fwd_offset;
  logic [8:0]  col_lo, col_hi, row_lo, row_hi;
  longint      sens_x, sens_y;
  logic [15:0] sens_hd;
  int unsigned beam_idx, free_hits;
  bit          pose_bad;

  score_t      score_q[$];
  int unsigned err_cnt;
  longint      cyc;
  int unsigned send_idle_pct, recv_stall_pct;
  bit          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sine in Q14 by the quadrant polynomial.
  function automatic longint sine_q14(logic [15:0] ph);
    logic [1:0]  quad;
    longint      x, s, t, y;
    ph   = ph & lbes_pkg::ANGLE_MASK;
    quad = ph[15:14];
    x    = ph[13:0];
    if (quad[0]) x = 16384 - x;
    s = (x * x) >>> 14;
    t = 10512 - ((1160 * s) >>> 14);
    t = 25736 - ((t * s) >>> 14);
    y = (t * x) >>> 14;
    return quad[1] ? -y : y;
  endfunction

  // Divide by 2^14 rounding half up.
  function automatic longint round_q14(longint v);
    longint w;
    w = v + 8192;
    if (w >= 0) return w >>> 14;
    return -(((-w) + 16383) >>> 14);
  endfunction

  // 0 free, 1 occupied, 2 off the grid.
  function automatic int cell_kind(longint x, longint y);
    longint c, r;
    if (x < 0 || y < 0) return 2;
    c = x >>> lbes_pkg::FRAC_BITS;
    r = y >>> lbes_pkg::FRAC_BITS;
    if (c >= 512 || r >= 512) return 2;
    return grid_occ[(r << 9) | c] ? 1 : 0;
  endfunction

  task automatic reset_mirror();
    foreach (grid_occ[i]) grid_occ[i] = 1'b0;
    win_lo = '0; win_hi = 18'h3FFFF; beam_step = 16'd91; fwd_offset = '0;
    col_lo = '0; col_hi = 9'd511; row_lo = '0; row_hi = 9'd511;
    sens_x = 0; sens_y = 0; sens_hd = '0; beam_idx = 0; free_hits = 0;
    pose_bad = 1'b0;
  endtask

  // Predictor: updates the mirror for one accepted item.
  task automatic score_item(lbes_pkg::action_e act, logic [8:0] r, logic [8:0] c,
                            logic occ, logic [16:0] px, logic [16:0] py,
                            logic [15:0] hd, logic [17:0] rng, logic lst);
    logic [15:0] ang;
    longint      ex, ey;
    score_t      sc;
    case (act)
      lbes_pkg::ACT_MAP: grid_occ[{r, c}] = occ;
      lbes_pkg::ACT_POSE: begin
        sens_x = px + round_q14(longint'(fwd_offset) * sine_q14(hd + 16'd16384));
        sens_y = py + round_q14(longint'(fwd_offset) * sine_q14(hd));
        sens_hd = hd;
        beam_idx = 0;
        free_hits = 0;
        pose_bad = cell_kind(px, py) != 0 || cell_kind(sens_x, sens_y) != 0;
      end
      lbes_pkg::ACT_BEAM: begin
        if (!pose_bad && rng >= win_lo && rng <= win_hi) begin
          ang = sens_hd + 16'd32768 + 16'(beam_idx * beam_step);
          ex = sens_x + round_q14(longint'(rng) * sine_q14(ang + 16'd16384));
          ey = sens_y + round_q14(longint'(rng) * sine_q14(ang));
          if (ex >= (longint'(col_lo) << lbes_pkg::FRAC_BITS)
              && ex <= (longint'(col_hi) << lbes_pkg::FRAC_BITS)
              && ey >= (longint'(row_lo) << lbes_pkg::FRAC_BITS)
              && ey <= (longint'(row_hi) << lbes_pkg::FRAC_BITS)
              && cell_kind(ex, ey) == 0 && free_hits < 1023)
            free_hits++;
        end
        if (lst || beam_idx + 1 >= lbes_pkg::BEAMS) begin
          sc.weight  = pose_bad ? 10'd0 : 10'(free_hits);
          sc.blocked = pose_bad;
          score_q.push_back(sc);
          beam_idx = 0;
          free_hits = 0;
        end else begin
          beam_idx = (beam_idx + 1) & 10'h3FF;
        end
      end
      default: ;
    endcase
  endtask

  // Sends one item and waits for its beat; valid stays high into the next item
  // and drops only when the sender pauses.
  task automatic send_item(lbes_pkg::action_e act, logic [8:0] r = 0, logic [8:0] c = 0,
                           logic occ = 0, logic [16:0] px = 0, logic [16:0] py = 0,
                           logic [15:0] hd = 0, logic [17:0] rng = 0, logic lst = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    cell_row_i      <= r;
    cell_col_i      <= c;
    cell_occupied_i <= occ;
    pose_x_i        <= px;
    pose_y_i        <= py;
    pose_heading_i  <= hd;
    beam_range_i    <= rng;
    last_beam_i     <= lst;
    do @(posedge clk_i); while (in_stall_o);
    score_item(act, r, c, occ, px, py, hd, rng, lst);
  endtask

  // Waits until every expected score has come, then lets the pipe drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(lbes_pkg::cfg_idx_e idx, logic [17:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      lbes_pkg::CFG_RANGE_MIN:  win_lo = val;
      lbes_pkg::CFG_RANGE_MAX:  win_hi = val;
      lbes_pkg::CFG_ANGLE_STEP: beam_step = val[15:0];
      lbes_pkg::CFG_SENSOR_OFF: fwd_offset = val[15:0];
      lbes_pkg::CFG_X_MIN:      col_lo = val[8:0];
      lbes_pkg::CFG_X_MAX:      col_hi = val[8:0];
      lbes_pkg::CFG_Y_MIN:      row_lo = val[8:0];
      default:                  row_hi = val[8:0];
    endcase
  endtask

  // Receiver stall and result check.
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (score_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected score beat: weight %0d", weight_o);
      end else begin
        want = score_q.pop_front();
        if (want.weight !== weight_o || want.blocked !== pose_blocked_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("Score mismatch: expected %0d/%0b, got %0d/%0b",
                     want.weight, want.blocked, weight_o, pose_blocked_o);
        end
      end
    end
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off, counted in cycles.
  task automatic hold_receiver(int unsigned cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  task automatic random_beams(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(lbes_pkg::ACT_BEAM, .rng(18'($urandom)), .lst($urandom_range(7) == 0));
  endtask

  // Random map writes, empty items and scans; a scan is a pose, then a run of beams ending in the last flag.
  task automatic random_scans(int unsigned items);
    int unsigned k, len, sel;
    k = 0;
    while (k < items) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        send_item(lbes_pkg::ACT_MAP, 9'($urandom), 9'($urandom),
                  .occ($urandom_range(3) == 0));
        k++;
      end else if (sel < 15) begin
        send_item(lbes_pkg::ACT_NONE, 9'($urandom), 9'($urandom), 1'($urandom),
                  17'($urandom), 17'($urandom), 16'($urandom), 18'($urandom),
                  1'($urandom));
      end else begin
        send_item(lbes_pkg::ACT_POSE,
                  .px(17'($urandom_range(sel < 20 ? 131071 : 40000, 0))),
                  .py(17'($urandom_range(sel < 20 ? 131071 : 40000, 0))),
                  .hd(16'($urandom)));
        len = $urandom_range(12, 1);
        for (int unsigned j = 0; j < len; j++)
          send_item(lbes_pkg::ACT_BEAM,
                    .rng(sel < 25 ? 18'($urandom) : 18'($urandom_range(6000, 0))),
                    .lst(j == len - 1));
        k += len + 1;
      end
    end
  endtask

  task automatic test_directed();
    send_item(lbes_pkg::ACT_BEAM, .rng(18'd500), .lst(1'b1));         // beam without pose
    send_item(lbes_pkg::ACT_MAP, 9'd511, 9'd511, 1'b1);
    send_item(lbes_pkg::ACT_MAP, 9'd0, 9'd0, 1'b1);
    send_item(lbes_pkg::ACT_POSE, .px(17'd128), .py(17'd64), .hd(16'd0)); // blocked pose
    send_item(lbes_pkg::ACT_BEAM, .rng(18'd300), .lst(1'b1));
    send_item(lbes_pkg::ACT_MAP, 9'd0, 9'd0, 1'b0);
    send_item(lbes_pkg::ACT_POSE, .px(17'h1FFFF), .py(17'h1FFFF),
              .hd(16'hFFFF));                                         // blocked pose in the far corner
    send_item(lbes_pkg::ACT_BEAM, .rng(18'd0), .lst(1'b1));
    send_item(lbes_pkg::ACT_POSE, .px(17'd60000), .py(17'd60000), .hd(16'h4000));
    send_item(lbes_pkg::ACT_BEAM, .rng(18'h3FFFF));                   // endpoint off grid
    send_item(lbes_pkg::ACT_BEAM, .rng(18'd0));
    send_item(lbes_pkg::ACT_BEAM, .rng(18'd2000));
    send_item(lbes_pkg::ACT_NONE, 9'h1FF, 9'h1FF, 1'b1, 17'h1FFFF, 17'h1FFFF, 16'hFFFF,
              18'h3FFFF, 1'b1);
    send_item(lbes_pkg::ACT_BEAM, .rng(18'd2000), .lst(1'b1));
    send_item(lbes_pkg::ACT_POSE, .px(17'd8000), .py(17'd8000), .hd(16'h8000));
    for (int unsigned i = 0; i < lbes_pkg::BEAMS; i++)               // end by beam count
      send_item(lbes_pkg::ACT_BEAM, .rng(18'd256));
    drain();
  endtask

  task automatic test_settings();
    // Narrow window, full step, negative offset, small bounding box.
    write_reg(lbes_pkg::CFG_RANGE_MIN, 18'd1000);
    write_reg(lbes_pkg::CFG_RANGE_MAX, 18'd3000);
    write_reg(lbes_pkg::CFG_ANGLE_STEP, 18'hFFFF);
    write_reg(lbes_pkg::CFG_SENSOR_OFF, 18'h8000);
    write_reg(lbes_pkg::CFG_X_MIN, 18'd100);
    write_reg(lbes_pkg::CFG_X_MAX, 18'd200);
    write_reg(lbes_pkg::CFG_Y_MIN, 18'd100);
    write_reg(lbes_pkg::CFG_Y_MAX, 18'd200);
    random_scans(150);
    drain();
    write_reg(lbes_pkg::CFG_RANGE_MIN, 18'h3FFFF);
    write_reg(lbes_pkg::CFG_RANGE_MAX, 18'd0);
    write_reg(lbes_pkg::CFG_ANGLE_STEP, 18'd0);
    write_reg(lbes_pkg::CFG_SENSOR_OFF, 18'h7FFF);
    write_reg(lbes_pkg::CFG_X_MIN, 18'd511);
    write_reg(lbes_pkg::CFG_X_MAX, 18'd0);
    random_scans(100);
    drain();
    write_reg(lbes_pkg::CFG_RANGE_MIN, 18'd0);
    write_reg(lbes_pkg::CFG_RANGE_MAX, 18'h3FFFF);
    write_reg(lbes_pkg::CFG_ANGLE_STEP, 18'd91);
    write_reg(lbes_pkg::CFG_SENSOR_OFF, 18'd300);
    write_reg(lbes_pkg::CFG_X_MIN, 18'd0);
    write_reg(lbes_pkg::CFG_X_MAX, 18'd511);
    write_reg(lbes_pkg::CFG_Y_MIN, 18'd0);
    write_reg(lbes_pkg::CFG_Y_MAX, 18'd511);
    random_scans(150);
    drain();
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 86; recv_stall_pct = 0;  random_scans(200);
    send_idle_pct = 0;  recv_stall_pct = 86; random_scans(200);
    send_idle_pct = 25; recv_stall_pct = 25; random_scans(200);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_scans(200);
    random_beams(50);
    drain();
  endtask

  task automatic test_backpressure();
    fork
      hold_receiver(400);
      random_scans(200);
    join
    drain();
  endtask

  initial begin
    err_cnt = 0; hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 1'b0; cfg_we_i = 0; cfg_idx_i = lbes_pkg::CFG_RANGE_MIN; cfg_data_i = 0;
    in_valid_i = 0; action_i = lbes_pkg::ACT_MAP; cell_row_i = 0; cell_col_i = 0;
    cell_occupied_i = 0; pose_x_i = 0; pose_y_i = 0; pose_heading_i = 0;
    beam_range_i = 0; last_beam_i = 0; out_stall_i = 0;
    reset_mirror();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_idle_phases();
    test_backpressure();
    if (err_cnt == 0 && score_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
